FILE: rtl/pida_pkg.sv
// Package for the positional insert/delete array: sizes, codes and the
// command/status structs shared by controller and datapath.
// No dependencies.
package pida_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int POS_W       = 6;
    localparam int IO_DATA_W   = 32;
    localparam int OUT_COUNT_W = 7;

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CUR_HOLD       = 3'd0,
        CUR_LOAD_COUNT = 3'd1,
        CUR_LOAD_POS   = 3'd2,
        CUR_DEC        = 3'd3,
        CUR_INC        = 3'd4
    } cursor_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } count_op_t;

    typedef enum logic [1:0] {
        RD_PREV = 2'd0,
        RD_NEXT = 2'd1,
        RD_POS  = 2'd2
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT  = 1'b0,
        WR_INSERT = 1'b1
    } wr_sel_t;

    typedef struct packed {
        logic       capture_item;
        logic       latch_check;
        cursor_op_t cursor_op;
        count_op_t  count_op;
        logic       ram_rd_en;
        rd_sel_t    rd_sel;
        logic       ram_wr_en;
        wr_sel_t    wr_sel;
        logic       load_result;
        logic       result_use_rdata;
    } pida_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       check_ok;
        logic       cursor_gt_pos;
        logic       more_to_move;
        logic       slot_free;
    } pida_sts_t;

    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [IO_DATA_W-1:0] v);
        logic signed [63:0] t;
        t = 64'(signed'(v));
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [IO_DATA_W-1:0] to_io(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] t;
        t = 64'(signed'(w));
        return t[IO_DATA_W-1:0];
    endfunction

    function automatic logic [OUT_COUNT_W-1:0] count_to_io(input logic [COUNT_W-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[OUT_COUNT_W-1:0];
    endfunction

endpackage

FILE: rtl/pida_req_if.sv
// Request channel: operation items into the array.
// Depends on pida_pkg.
interface pida_req_if import pida_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [POS_W-1:0]            position;
    logic signed [IO_DATA_W-1:0] data_value;

    modport source (output valid, output opcode, output position, output data_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input data_value,
                    output ready);
endinterface

FILE: rtl/pida_rsp_if.sv
// Response channel: one result item per operation.
// Depends on pida_pkg.
interface pida_rsp_if import pida_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic signed [IO_DATA_W-1:0] read_data;
    logic [OUT_COUNT_W-1:0]      element_count;

    modport source (output valid, output status, output read_data, output element_count,
                    input ready);
    modport sink   (input valid, input status, input read_data, input element_count,
                    output ready);
endinterface

FILE: rtl/pida_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/pida_datapath.sv
// Datapath: item registers, count, shift cursor, element RAM and result register.
// Depends on pida_pkg and pida_ram.
module pida_datapath import pida_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pida_cmd_t            cmd,
    output pida_sts_t            sts,
    input  logic [1:0]           opcode,
    input  logic [POS_W-1:0]     position,
    input  logic [IO_DATA_W-1:0] data_value,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output logic [1:0]           status,
    output logic [IO_DATA_W-1:0] read_data,
    output logic [OUT_COUNT_W-1:0] element_count
);

    logic [1:0]            op_reg;
    logic [CMP_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [COUNT_W-1:0]    cursor_reg;
    logic [COUNT_W-1:0]    cursor_next;
    status_t               check_reg;
    status_t               check_code;

    logic                   rsp_valid_reg;
    logic [1:0]             status_reg;
    logic [IO_DATA_W-1:0]   read_data_reg;
    logic [OUT_COUNT_W-1:0] count_out_reg;

    logic [CMP_W-1:0]      count_cmp;
    logic [CMP_W-1:0]      cursor_cmp;
    logic [COUNT_W-1:0]    cursor_m1;
    logic [COUNT_W:0]      cursor_p1;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign count_cmp  = CMP_W'(count_reg);
    assign cursor_cmp = CMP_W'(cursor_reg);
    assign cursor_m1  = cursor_reg - COUNT_W'(1);
    assign cursor_p1  = {1'b0, cursor_reg} + (COUNT_W + 1)'(1);

    always_comb
    begin
        check_code = ST_BADPOS;
        unique case (op_reg) inside
            OP_INSERT:
            begin
                if (count_reg >= COUNT_W'(CAPACITY))
                    check_code = ST_FULL;
                else if (pos_reg > count_cmp)
                    check_code = ST_BADPOS;
                else
                    check_code = ST_OK;
            end
            OP_DELETE, OP_READ:
            begin
                if (count_reg == '0)
                    check_code = ST_EMPTY;
                else if (pos_reg >= count_cmp)
                    check_code = ST_BADPOS;
                else
                    check_code = ST_OK;
            end
            default: check_code = ST_BADPOS;
        endcase
    end

    assign sts.op            = op_reg;
    assign sts.check_ok      = (check_code == ST_OK);
    assign sts.cursor_gt_pos = (cursor_cmp > pos_reg);
    assign sts.more_to_move  = (cursor_p1 < {1'b0, count_reg});
    assign sts.slot_free     = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_addr = cursor_m1[ADDR_W-1:0];
            RD_NEXT: rd_addr = cursor_p1[ADDR_W-1:0];
            RD_POS:  rd_addr = pos_reg[ADDR_W-1:0];
            default: rd_addr = pos_reg[ADDR_W-1:0];
        endcase
        case (cmd.wr_sel)
            WR_INSERT:
            begin
                wr_addr = pos_reg[ADDR_W-1:0];
                wr_data = word_reg;
            end
            default:
            begin
                wr_addr = cursor_reg[ADDR_W-1:0];
                wr_data = ram_rdata;
            end
        endcase
    end

    pida_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.ram_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.ram_rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        case (cmd.cursor_op)
            CUR_LOAD_COUNT: cursor_next = count_reg;
            CUR_LOAD_POS:   cursor_next = COUNT_W'(pos_reg);
            CUR_DEC:        cursor_next = cursor_m1;
            CUR_INC:        cursor_next = cursor_p1[COUNT_W-1:0];
            default:        cursor_next = cursor_reg;
        endcase
        case (cmd.count_op)
            CNT_INC: count_next = count_reg + COUNT_W'(1);
            CNT_DEC: count_next = count_reg - COUNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_item)
        begin
            op_reg   <= opcode;
            pos_reg  <= CMP_W'(position);
            word_reg <= to_word(data_value);
        end
        if (cmd.latch_check)
        begin
            check_reg <= check_code;
        end
        cursor_reg <= cursor_next;
        if (cmd.load_result)
        begin
            status_reg    <= check_reg;
            read_data_reg <= cmd.result_use_rdata ? to_io(ram_rdata) : '0;
            count_out_reg <= count_to_io(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_result)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign read_data     = read_data_reg;
    assign element_count = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwritten before taken");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.count_op == CNT_HOLD) |=> (count_reg == $past(count_reg)))
        else $error("count moved without command");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_wr_en |-> (32'(wr_addr) < CAPACITY))
        else $error("write beyond capacity");

endmodule

FILE: rtl/pida_ctrl.sv
// Controller state machine: sequences check, shift loop, read and result load.
// Depends on pida_pkg.
module pida_ctrl import pida_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  pida_sts_t sts,
    output pida_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CHECK    = 8'b0000_0010,
        S_INS_TEST = 8'b0000_0100,
        S_INS_WR   = 8'b0000_1000,
        S_DEL_TEST = 8'b0001_0000,
        S_DEL_WR   = 8'b0010_0000,
        S_RD_WAIT  = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_fire;

    assign req_ready = (state_reg == S_IDLE) && sts.slot_free;
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        cmd = '0;
        cmd.cursor_op = CUR_HOLD;
        cmd.count_op  = CNT_HOLD;
        cmd.rd_sel    = RD_POS;
        cmd.wr_sel    = WR_SHIFT;
        state_next    = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture_item = req_fire;
                if (req_fire)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.latch_check = 1'b1;
                if (!sts.check_ok)
                    state_next = S_FINISH;
                else if (sts.op == OP_INSERT)
                begin
                    cmd.cursor_op = CUR_LOAD_COUNT;
                    state_next    = S_INS_TEST;
                end
                else if (sts.op == OP_DELETE)
                begin
                    cmd.cursor_op = CUR_LOAD_POS;
                    state_next    = S_DEL_TEST;
                end
                else
                begin
                    cmd.ram_rd_en = 1'b1;
                    cmd.rd_sel    = RD_POS;
                    state_next    = S_RD_WAIT;
                end
            end
            S_INS_TEST:
            begin
                if (sts.cursor_gt_pos)
                begin
                    cmd.ram_rd_en = 1'b1;
                    cmd.rd_sel    = RD_PREV;
                    state_next    = S_INS_WR;
                end
                else
                begin
                    cmd.ram_wr_en = 1'b1;
                    cmd.wr_sel    = WR_INSERT;
                    cmd.count_op  = CNT_INC;
                    state_next    = S_FINISH;
                end
            end
            S_INS_WR:
            begin
                cmd.ram_wr_en = 1'b1;
                cmd.wr_sel    = WR_SHIFT;
                cmd.cursor_op = CUR_DEC;
                state_next    = S_INS_TEST;
            end
            S_DEL_TEST:
            begin
                if (sts.more_to_move)
                begin
                    cmd.ram_rd_en = 1'b1;
                    cmd.rd_sel    = RD_NEXT;
                    state_next    = S_DEL_WR;
                end
                else
                begin
                    cmd.count_op = CNT_DEC;
                    state_next   = S_FINISH;
                end
            end
            S_DEL_WR:
            begin
                cmd.ram_wr_en = 1'b1;
                cmd.wr_sel    = WR_SHIFT;
                cmd.cursor_op = CUR_INC;
                state_next    = S_DEL_TEST;
            end
            S_RD_WAIT:
            begin
                cmd.load_result      = 1'b1;
                cmd.result_use_rdata = 1'b1;
                state_next           = S_IDLE;
            end
            S_FINISH:
            begin
                cmd.load_result = 1'b1;
                state_next      = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_CHECK))
        else $error("accepted item not checked");

    a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> (state_reg == S_IDLE))
        else $error("result load did not end the item");

    a_shift_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ram_wr_en && cmd.wr_sel == WR_SHIFT) |-> $past(cmd.ram_rd_en))
        else $error("shift write without prior read");

endmodule

FILE: rtl/positional_insert_delete_array_core.sv
// Positional insert/delete array. Each item is checked; insert then shifts entries
// up from the end to the position and writes the word, delete shifts later entries
// down, read fetches the entry, a failed check goes straight to the result. One item
// is in flight at a time; the next is taken when idle with the result slot free. The
// RAM read is registered, so each entry moved takes a read and a write step. Reset
// clears count, state and result valid; RAM contents are undefined until written.
module positional_insert_delete_array_core import pida_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pida_req_if.sink  req,
    pida_rsp_if.source rsp
);

    pida_cmd_t cmd;
    pida_sts_t sts;

    pida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pida_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (req.opcode),
        .position      (req.position),
        .data_value    (req.data_value),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .status        (rsp.status),
        .read_data     (rsp.read_data),
        .element_count (rsp.element_count)
    );

endmodule
